// File: sv/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, widths and helpers of the linear probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_SIZE = 32;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;
  localparam int ENTRY_W  = KEY_W + DATA_W;

  localparam int IN_BITS  = OP_W + KEY_W + DATA_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + DATA_W + SLOT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef struct packed {
    logic  en;
    idx_t  idx;
    mark_t mark;
  } mark_wr_t;

  function automatic idx_t home_slot(input logic [KEY_W-1:0] key);
    home_slot = IDX_W'(key % TABLE_SIZE);
  endfunction

endpackage

// File: sv/lpht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lpht_marks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_marks
// Per-slot occupancy marks held in flip-flops and cleared to empty on reset.
// ----------------------------------------------------------------------------
module lpht_marks (
  input  logic              clk,
  input  logic              rst,
  input  lpht_pkg::mark_wr_t wr,
  input  lpht_pkg::idx_t    rd_idx,
  output lpht_pkg::mark_t   rd_mark
);
  import lpht_pkg::*;

  mark_t marks [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        marks[i] <= MARK_EMPTY;
      end
    end else if (wr.en) begin
      marks[wr.idx] <= wr.mark;
    end
  end

  assign rd_mark = marks[rd_idx];

endmodule

// File: sv/linear_probe_hash_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open addressing hash table of 32 slots with linear probing.
// ----------------------------------------------------------------------------
// One beat is taken in the idle state, then the sequencer probes one slot per
// cycle from the home slot (key mod 32) while the output register is free; an
// item probes from 1 up to 32 slots. The single read port of the key and data
// memory sets that pace. Slot marks live in flip-flops that reset clears at
// once, so no clearing pass follows reset. A finished result waits in the
// output register while the next beat is taken; the probe of that beat holds
// until the register is free.
module linear_probe_hash_table_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // op [1:0], key [32:2], write_data [64:33], zero fill above.
  input  logic [lpht_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status [1:0], read_data [33:2], slot [38:34], zero fill above.
  output logic [lpht_pkg::OUT_W-1:0] m_tdata
);
  import lpht_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                    state;
  logic [OP_W-1:0]           op;
  logic [KEY_W-1:0]          key;
  logic signed [DATA_W-1:0]  write_data;
  idx_t                      cmp_idx;
  idx_t                      cnt;

  logic [KEY_W-1:0]          in_key;
  idx_t                      next_idx;
  idx_t                      raddr;
  logic [ENTRY_W-1:0]        rdata;
  logic [KEY_W-1:0]          rd_key;
  logic signed [DATA_W-1:0]  rd_value;
  mark_t                     mark_cur;
  mark_wr_t                  mark_wr;
  logic                      out_free;
  logic                      out_load;
  logic                      last_probe;
  logic                      finish;
  logic                      do_write;
  status_t                   res_status;
  logic signed [DATA_W-1:0]  res_data;
  idx_t                      res_slot;

  assign in_key     = s_tdata[OP_W +: KEY_W];
  assign rd_key     = rdata[DATA_W +: KEY_W];
  assign rd_value   = rdata[DATA_W-1:0];
  assign s_tready   = (state == S_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign out_load   = (state == S_SCAN) && out_free && finish;
  assign last_probe = (cnt == IDX_W'(TABLE_SIZE - 1));
  assign next_idx   = (cmp_idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : cmp_idx + 1'b1;

  always_comb begin
    finish     = 1'b0;
    do_write   = 1'b0;
    res_status = ST_MISS;
    res_data   = '0;
    res_slot   = '0;
    mark_wr    = '{en: 1'b0, idx: cmp_idx, mark: MARK_USED};
    if (state == S_SCAN) begin
      case (op) inside
        OP_INSERT: begin
          if (mark_cur != MARK_USED) begin
            finish     = 1'b1;
            do_write   = 1'b1;
            res_status = ST_OK;
            res_slot   = cmp_idx;
            mark_wr.en = 1'b1;
          end else if (last_probe) begin
            finish     = 1'b1;
            res_status = ST_FULL;
          end
        end
        OP_SEARCH, OP_DELETE: begin
          if (mark_cur == MARK_EMPTY) begin
            finish = 1'b1;
          end else if (mark_cur == MARK_USED && rd_key == key) begin
            finish     = 1'b1;
            res_status = ST_OK;
            res_data   = rd_value;
            res_slot   = cmp_idx;
            if (op == OP_DELETE) begin
              mark_wr.en   = 1'b1;
              mark_wr.mark = MARK_TOMB;
            end
          end else if (last_probe) begin
            finish = 1'b1;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
    do_write   = do_write && out_free;
    mark_wr.en = mark_wr.en && out_free;
  end

  always_comb begin
    if (state == S_IDLE) begin
      raddr = home_slot(in_key);
    end else if (finish || !out_free) begin
      raddr = cmp_idx;
    end else begin
      raddr = next_idx;
    end
  end

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_entries (
    .clk   (clk),
    .we    (do_write),
    .waddr (cmp_idx),
    .wdata ({key, write_data}),
    .raddr (raddr),
    .rdata (rdata)
  );

  lpht_marks u_marks (
    .clk     (clk),
    .rst     (rst),
    .wr      (mark_wr),
    .rd_idx  (cmp_idx),
    .rd_mark (mark_cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= s_tdata[OP_W-1:0];
            key        <= in_key;
            write_data <= s_tdata[OP_W+KEY_W +: DATA_W];
            cmp_idx    <= home_slot(in_key);
            cnt        <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (out_free) begin
            if (finish) begin
              m_tdata  <= {(OUT_W - OUT_BITS)'(0), SLOT_W'(res_slot), res_data, res_status};
              state    <= S_IDLE;
            end else begin
              cmp_idx <= next_idx;
              cnt     <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the linear probe hash table, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [lpht_pkg::IN_W-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [lpht_pkg::OUT_W-1:0] m_tdata
);
  import lpht_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [DATA_W-1:0]   rd;
  logic [SLOT_W-1:0]   sl;
  logic                in_beat;

  assign st      = m_tdata[STATUS_W-1:0];
  assign rd      = m_tdata[STATUS_W +: DATA_W];
  assign sl      = m_tdata[STATUS_W+DATA_W +: SLOT_W];
  assign in_beat = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result beat valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result beat changed.");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready)
    else $error("Input taken again before the probe ran.");

  a_miss_is_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st != ST_OK |-> rd == '0 && sl == '0)
    else $error("Miss or full result carries data or a slot.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> st == ST_OK || st == ST_MISS || st == ST_FULL)
    else $error("Result status code out of range.");

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
